/* rtl/core/mws_pkg.sv */
// shared types and constants for the multichannel window statistics block
package mws_pkg;

	localparam int CHANNELS   = 7;
	localparam int SIGNED_CH  = 3;
	localparam int IN_W       = 16;
	localparam int VAL_W      = 17;
	localparam int CH_W       = 3;
	localparam int WLEN_W     = 11;
	localparam int WLEN_RESET = 60;
	localparam int SQ_IN_W    = 32;
	localparam int SQ_OUT_W   = 16;
	localparam logic [CH_W-1:0] LAST_CH = 3'd6;

	typedef logic [CH_W-1:0] ch_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACC,
		OP_MEAN,
		OP_MUL1,
		OP_MUL2,
		OP_DIV1,
		OP_DIV2,
		OP_SQRT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic take;
		op_t  op;
		ch_t  ch;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic mul_done;
		logic sqrt_done;
	} sts_t;

endpackage

/* rtl/core/mws_div.sv */
// iterative restoring divider, one quotient bit per cycle
module mws_div #(
	parameter int DW = 8,
	parameter int VW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quot,
	output logic          rem_nz,
	output logic          done
);

	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] d_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   r2;
	logic [VW:0]   rn;
	logic          ge;

	always_comb begin
		r2 = {rem_q, quot_q[DW-1]};
		ge = r2 >= {1'b0, d_q};
		rn = ge ? r2 - {1'b0, d_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(DW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			d_q    <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= rn[VW-1:0];
		end
	end

	assign quot   = quot_q;
	assign rem_nz = rem_q != '0;
	assign done   = done_q;

endmodule

/* rtl/core/mws_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, product truncated to AW
module mws_mul #(
	parameter int AW = 8,
	parameter int BW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW-1:0] prod,
	output logic          done
);

	localparam int KW = $clog2(BW + 1);

	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [AW-1:0] acc_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(BW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

/* rtl/core/mws_sqrt.sv */
// digit-by-digit integer square root, one root bit per cycle
module mws_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mws_pkg::SQ_IN_W-1:0]  value,
	output logic [mws_pkg::SQ_OUT_W-1:0] root,
	output logic                         done
);

	localparam int RW = mws_pkg::SQ_OUT_W;
	localparam int KW = $clog2(RW + 1);

	logic [mws_pkg::SQ_IN_W-1:0] v_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [RW+3:0] r2;
	logic [RW+3:0] trial;
	logic          ge;

	always_comb begin
		r2    = {rem_q, v_q[mws_pkg::SQ_IN_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(RW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q    <= {v_q[mws_pkg::SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

/* rtl/core/mws_ctrl.sv */
// controller: sequences accumulation and the end-of-window statistics
module mws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output mws_pkg::cmd_t cmd,
	input  mws_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_CHECK,
		S_MEAN,
		S_MUL1,
		S_MUL2,
		S_DIV1,
		S_DIV2,
		S_SQRT,
		S_EMIT
	} state_t;

	state_t          state_q;
	mws_pkg::op_t    op_q;
	mws_pkg::ch_t    ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= mws_pkg::OP_NONE;
			ch_q    <= '0;
		end else begin
			op_q <= mws_pkg::OP_NONE;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ACC;
						op_q    <= mws_pkg::OP_ACC;
						ch_q    <= '0;
					end
				end
				S_ACC: begin
					if (ch_q == mws_pkg::LAST_CH) begin
						state_q <= S_CHECK;
						ch_q    <= '0;
					end else begin
						op_q <= mws_pkg::OP_ACC;
						ch_q <= ch_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (sts.close) begin
						state_q <= S_MEAN;
						op_q    <= mws_pkg::OP_MEAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MEAN: begin
					if (sts.div_done) begin
						state_q <= S_MUL1;
						op_q    <= mws_pkg::OP_MUL1;
					end
				end
				S_MUL1: begin
					if (sts.mul_done) begin
						state_q <= S_MUL2;
						op_q    <= mws_pkg::OP_MUL2;
					end
				end
				S_MUL2: begin
					if (sts.mul_done) begin
						state_q <= S_DIV1;
						op_q    <= mws_pkg::OP_DIV1;
					end
				end
				S_DIV1: begin
					if (sts.div_done) begin
						state_q <= S_DIV2;
						op_q    <= mws_pkg::OP_DIV2;
					end
				end
				S_DIV2: begin
					if (sts.div_done) begin
						state_q <= S_SQRT;
						op_q    <= mws_pkg::OP_SQRT;
					end
				end
				S_SQRT: begin
					if (sts.sqrt_done) begin
						state_q <= S_EMIT;
						op_q    <= mws_pkg::OP_EMIT;
					end
				end
				S_EMIT: begin
					if (ch_q == mws_pkg::LAST_CH) begin
						state_q <= S_IDLE;
						ch_q    <= '0;
					end else begin
						state_q <= S_MEAN;
						op_q    <= mws_pkg::OP_MEAN;
						ch_q    <= ch_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = state_q != S_IDLE;
	assign cmd.take = start && state_q == S_IDLE;
	assign cmd.op   = op_q;
	assign cmd.ch   = ch_q;

endmodule

/* rtl/core/mws_dp.sv */
// datapath: per-channel accumulators, window count and statistics units
module mws_dp #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mws_pkg::cmd_t                 cmd,
	output mws_pkg::sts_t                 sts,
	input  logic                          wr_en,
	input  logic [mws_pkg::WLEN_W-1:0]    wr_data,
	input  logic signed [mws_pkg::IN_W-1:0] accel_x,
	input  logic signed [mws_pkg::IN_W-1:0] accel_y,
	input  logic signed [mws_pkg::IN_W-1:0] accel_z,
	input  logic [mws_pkg::IN_W-1:0]      light_clear,
	input  logic [mws_pkg::IN_W-1:0]      light_red,
	input  logic [mws_pkg::IN_W-1:0]      light_blue,
	input  logic [mws_pkg::IN_W-1:0]      light_green,
	output logic                          strobe,
	output logic [mws_pkg::CH_W-1:0]      channel,
	output logic signed [mws_pkg::VAL_W-1:0] minimum,
	output logic signed [mws_pkg::VAL_W-1:0] maximum,
	output logic signed [mws_pkg::VAL_W-1:0] mean,
	output logic [mws_pkg::SQ_OUT_W-1:0]  std_dev,
	output logic                          last
);

	localparam int VW  = mws_pkg::VAL_W;
	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int SW  = VW + CW;
	localparam int MW  = SW - 1;
	localparam int SQW = 2 * mws_pkg::IN_W + CW;
	localparam int NW  = 2 * mws_pkg::IN_W + 2 * CW;
	localparam int LW  = (CW > mws_pkg::WLEN_W) ? CW + 1 : mws_pkg::WLEN_W + 1;
	localparam int NCH = mws_pkg::CHANNELS;

	logic [mws_pkg::WLEN_W-1:0] wlen_q;
	logic [CW-1:0]              cnt_q;
	logic signed [VW-1:0]       rec_q [NCH];
	logic signed [SW-1:0]       sum_q [NCH];
	logic [SQW-1:0]             sq_q  [NCH];
	logic signed [VW-1:0]       min_q [NCH];
	logic signed [VW-1:0]       max_q [NCH];
	logic [MW-1:0]              smag_q;
	logic                       sneg_q;
	logic [VW-1:0]              mean_q;
	logic [NW-1:0]              tmp_q;

	logic signed [VW-1:0]       in_val [NCH];
	logic signed [VW-1:0]       v;
	logic [mws_pkg::IN_W-1:0]   vmag;
	logic [2*mws_pkg::IN_W-1:0] vsq;
	logic signed [SW-1:0]       s;
	logic [SW-1:0]              sabs;
	logic [LW-1:0]              wl;
	logic [CW-1:0]              n;

	logic          div_start;
	logic [NW-1:0] div_dividend;
	logic [NW-1:0] div_quot;
	logic          div_rem_nz;
	logic          div_done;
	logic          mul_start;
	logic [NW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [NW-1:0] mul_prod;
	logic          mul_done;
	logic          sqrt_start;
	logic [mws_pkg::SQ_OUT_W-1:0] sqrt_root;
	logic          sqrt_done;
	logic [NW-1:0] num;

	always_comb begin
		in_val[0] = VW'(accel_x);
		in_val[1] = VW'(accel_y);
		in_val[2] = VW'(accel_z);
		in_val[3] = VW'({1'b0, light_clear});
		in_val[4] = VW'({1'b0, light_red});
		in_val[5] = VW'({1'b0, light_blue});
		in_val[6] = VW'({1'b0, light_green});
	end

	always_comb begin
		v    = rec_q[cmd.ch];
		vmag = v[VW-1] ? mws_pkg::IN_W'(-v) : v[mws_pkg::IN_W-1:0];
		vsq  = vmag * vmag;
		s    = sum_q[cmd.ch];
		sabs = s[SW-1] ? SW'(-s) : SW'(s);
	end

	// window length clamped to 1..MAX_WINDOW
	always_comb begin
		wl = LW'(wlen_q);
		if (wl == '0) begin
			n = CW'(1);
		end else if (wl > LW'(MAX_WINDOW)) begin
			n = CW'(MAX_WINDOW);
		end else begin
			n = wl[CW-1:0];
		end
	end

	assign num = (tmp_q >= mul_prod) ? tmp_q - mul_prod : '0;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = NW'(smag_q);
		mul_start    = 1'b0;
		mul_a        = NW'(sq_q[cmd.ch]);
		mul_b        = MW'(cnt_q);
		sqrt_start   = 1'b0;
		case (cmd.op)
			mws_pkg::OP_MEAN: begin
				div_start    = 1'b1;
				div_dividend = NW'(sabs[MW-1:0]);
			end
			mws_pkg::OP_MUL1: begin
				mul_start = 1'b1;
			end
			mws_pkg::OP_MUL2: begin
				mul_start = 1'b1;
				mul_a     = NW'(smag_q);
				mul_b     = smag_q;
			end
			mws_pkg::OP_DIV1: begin
				div_start    = 1'b1;
				div_dividend = num;
			end
			mws_pkg::OP_DIV2: begin
				div_start    = 1'b1;
				div_dividend = div_quot;
			end
			mws_pkg::OP_SQRT: begin
				sqrt_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mws_div #(.DW(NW), .VW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cnt_q),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz),
		.done     (div_done)
	);

	mws_mul #(.AW(NW), .BW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	mws_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (div_quot[mws_pkg::SQ_IN_W-1:0]),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	assign sts.close     = cnt_q >= n;
	assign sts.div_done  = div_done;
	assign sts.mul_done  = mul_done;
	assign sts.sqrt_done = sqrt_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= mws_pkg::WLEN_W'(mws_pkg::WLEN_RESET);
			cnt_q  <= '0;
			strobe <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else begin
			strobe <= 1'b0;
			if (wr_en) begin
				wlen_q <= wr_data;
			end
			if (cmd.op == mws_pkg::OP_ACC) begin
				sum_q[cmd.ch] <= sum_q[cmd.ch] + SW'(v);
				sq_q[cmd.ch]  <= sq_q[cmd.ch] + SQW'(vsq);
				if (cmd.ch == mws_pkg::LAST_CH) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.op == mws_pkg::OP_EMIT) begin
				strobe <= 1'b1;
				// window done: start the next one from zero
				if (cmd.ch == mws_pkg::LAST_CH) begin
					cnt_q <= '0;
					for (int i = 0; i < NCH; i++) begin
						sum_q[i] <= '0;
						sq_q[i]  <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int i = 0; i < NCH; i++) begin
				rec_q[i] <= in_val[i];
			end
		end
		if (cmd.op == mws_pkg::OP_ACC) begin
			// first record of a window loads min and max
			if (cnt_q == '0 || v < min_q[cmd.ch]) begin
				min_q[cmd.ch] <= v;
			end
			if (cnt_q == '0 || v > max_q[cmd.ch]) begin
				max_q[cmd.ch] <= v;
			end
		end
		case (cmd.op)
			mws_pkg::OP_MEAN: begin
				smag_q <= sabs[MW-1:0];
				sneg_q <= s[SW-1];
			end
			mws_pkg::OP_MUL1: begin
				// floor toward minus infinity for negative sums
				if (!sneg_q) begin
					mean_q <= div_quot[VW-1:0];
				end else if (div_rem_nz) begin
					mean_q <= ~div_quot[VW-1:0];
				end else begin
					mean_q <= ~div_quot[VW-1:0] + 1'b1;
				end
			end
			mws_pkg::OP_MUL2: begin
				tmp_q <= mul_prod;
			end
			mws_pkg::OP_EMIT: begin
				channel <= cmd.ch;
				minimum <= min_q[cmd.ch];
				maximum <= max_q[cmd.ch];
				mean    <= mean_q;
				std_dev <= sqrt_root;
				last    <= cmd.ch == mws_pkg::LAST_CH;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/multichannel_window_statistics.sv */
// top level of the multichannel window statistics block
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  record   | start, busy       | accel_x/y/z, light_clear/red/blue/green
//  result   | strobe            | channel, minimum, maximum, mean, std_dev, last
//  config   | wr_en             | wr_data (window_len)
//
// a record is taken when start is high and busy low; accumulation runs one channel a cycle,
// then the window count is checked.
// a closing record then runs, per channel, a mean division, two multiplies, two divisions
// and a square root (serial divider, shift-add multiplier and square root).
// reset clears counts and sums; window_len returns to 60.
// results are strobed for one cycle each and cannot be held off.
module multichannel_window_statistics #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             wr_en,
	input  logic [mws_pkg::WLEN_W-1:0]       wr_data,
	input  logic signed [mws_pkg::IN_W-1:0]  accel_x,
	input  logic signed [mws_pkg::IN_W-1:0]  accel_y,
	input  logic signed [mws_pkg::IN_W-1:0]  accel_z,
	input  logic [mws_pkg::IN_W-1:0]         light_clear,
	input  logic [mws_pkg::IN_W-1:0]         light_red,
	input  logic [mws_pkg::IN_W-1:0]         light_blue,
	input  logic [mws_pkg::IN_W-1:0]         light_green,
	output logic                             strobe,
	output logic [mws_pkg::CH_W-1:0]         channel,
	output logic signed [mws_pkg::VAL_W-1:0] minimum,
	output logic signed [mws_pkg::VAL_W-1:0] maximum,
	output logic signed [mws_pkg::VAL_W-1:0] mean,
	output logic [mws_pkg::SQ_OUT_W-1:0]     std_dev,
	output logic                             last
);

	mws_pkg::cmd_t cmd;
	mws_pkg::sts_t sts;

	mws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	mws_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.light_clear (light_clear),
		.light_red   (light_red),
		.light_blue  (light_blue),
		.light_green (light_green),
		.strobe      (strobe),
		.channel     (channel),
		.minimum     (minimum),
		.maximum     (maximum),
		.mean        (mean),
		.std_dev     (std_dev),
		.last        (last)
	);

endmodule

/* rtl/core/mws_chk.sv */
// port-level checker for the multichannel window statistics block, with its bind
module mws_chk (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     strobe,
	input logic [mws_pkg::CH_W-1:0] channel,
	input logic                     last
);

	// a taken item keeps the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after an item was taken");

	// only the seventh result of a window frees the block
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("block idle in the middle of a result burst");

	a_last_ch: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (channel == mws_pkg::LAST_CH)))
		else $error("last flag does not match the final channel");

	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results on adjacent cycles");

endmodule

bind multichannel_window_statistics mws_chk u_mws_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.channel (channel),
	.last    (last)
);

/* test/tb_top.sv */
// self-checking testbench for the multichannel window statistics block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1500000;
	localparam int MAXW  = 1024;

	typedef struct {
		logic [mws_pkg::CH_W-1:0]         chan;
		logic signed [mws_pkg::VAL_W-1:0] lo;
		logic signed [mws_pkg::VAL_W-1:0] hi;
		logic signed [mws_pkg::VAL_W-1:0] avg;
		logic [mws_pkg::SQ_OUT_W-1:0]     sd;
		logic                             fin;
	} stats_t;

	typedef struct {
		bit is_cfg;
		int wlen;
		bit glance;
		int v[mws_pkg::CHANNELS];
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic wr_en = 0;
	logic [mws_pkg::WLEN_W-1:0] wr_data = '0;
	logic signed [mws_pkg::IN_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic [mws_pkg::IN_W-1:0] light_clear = '0, light_red = '0;
	logic [mws_pkg::IN_W-1:0] light_blue = '0, light_green = '0;
	logic strobe;
	logic [mws_pkg::CH_W-1:0] channel;
	logic signed [mws_pkg::VAL_W-1:0] minimum, maximum, mean;
	logic [mws_pkg::SQ_OUT_W-1:0] std_dev;
	logic last;

	// predictor state
	int win_len;
	int rec_count;
	longint acc_sum [mws_pkg::CHANNELS];
	longint unsigned acc_sq [mws_pkg::CHANNELS];
	int run_min [mws_pkg::CHANNELS];
	int run_max [mws_pkg::CHANNELS];

	stats_t pending_stats[$];
	int errors = 0;
	int cycles = 0;

	multichannel_window_statistics dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.wr_en(wr_en), .wr_data(wr_data),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.light_clear(light_clear), .light_red(light_red),
		.light_blue(light_blue), .light_green(light_green),
		.strobe(strobe), .channel(channel), .minimum(minimum), .maximum(maximum),
		.mean(mean), .std_dev(std_dev), .last(last)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** multichannel_window_statistics: FAILED **");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// fold one record into the window, return the seven stats when it closes
	task automatic window_update(input int v[mws_pkg::CHANNELS], ref stats_t res[$]);
		int n;
		longint s, q, sn;
		longint unsigned mag, smag, num, var_q, root;
		stats_t r;
		n = (win_len < 1) ? 1 : (win_len > MAXW ? MAXW : win_len);
		for (int c = 0; c < mws_pkg::CHANNELS; c++) begin
			mag = longint'((v[c] < 0) ? -v[c] : v[c]);
			acc_sum[c] += longint'(v[c]);
			acc_sq[c] += mag * mag;
			if (rec_count == 0) begin
				run_min[c] = v[c];
				run_max[c] = v[c];
			end else begin
				if (v[c] < run_min[c]) run_min[c] = v[c];
				if (v[c] > run_max[c]) run_max[c] = v[c];
			end
		end
		rec_count++;
		if (rec_count < n) return;
		sn = longint'(rec_count);
		for (int c = 0; c < mws_pkg::CHANNELS; c++) begin
			s = acc_sum[c];
			q = s / sn;
			if (s % sn != 0 && s < 0) q -= 1;
			smag = (s < 0) ? -s : s;
			num = sn * acc_sq[c];
			num = (num >= smag * smag) ? num - smag * smag : 0;
			var_q = num / (sn * sn);
			root = int_sqrt(var_q);
			if (root > 65535) root = 65535;
			r.chan = mws_pkg::CH_W'(c);
			r.lo = mws_pkg::VAL_W'(run_min[c]);
			r.hi = mws_pkg::VAL_W'(run_max[c]);
			r.avg = mws_pkg::VAL_W'(q);
			r.sd = mws_pkg::SQ_OUT_W'(root);
			r.fin = (c == mws_pkg::CHANNELS - 1);
			res.push_back(r);
		end
		rec_count = 0;
		for (int c = 0; c < mws_pkg::CHANNELS; c++) begin
			acc_sum[c] = 0;
			acc_sq[c] = 0;
		end
	endtask

	always @(posedge clk) begin
		stats_t e;
		if (strobe) begin
			if (pending_stats.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result on channel %0d", channel);
			end else begin
				e = pending_stats.pop_front();
				if (channel !== e.chan || minimum !== e.lo || maximum !== e.hi ||
				    mean !== e.avg || std_dev !== e.sd || last !== e.fin) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp ch %0d min %0d max %0d mean %0d sd %0d last %0d",
							e.chan, e.lo, e.hi, e.avg, e.sd, e.fin);
						$display("          got ch %0d min %0d max %0d mean %0d sd %0d last %0d",
							channel, minimum, maximum, mean, std_dev, last);
					end
				end
			end
		end
	end

	task automatic send_record(input int v[mws_pkg::CHANNELS], input bit glance,
			input bit gaps);
		stats_t res[$];
		stats_t r;
		accel_x <= v[0][15:0];
		accel_y <= v[1][15:0];
		accel_z <= v[2][15:0];
		light_clear <= v[3][15:0];
		light_red <= v[4][15:0];
		light_blue <= v[5][15:0];
		light_green <= v[6][15:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		window_update(v, res);
		// single-record windows: the stats are the record itself
		if (glance) begin
			res.delete();
			for (int c = 0; c < mws_pkg::CHANNELS; c++) begin
				r.chan = mws_pkg::CH_W'(c);
				r.lo = mws_pkg::VAL_W'(v[c]);
				r.hi = mws_pkg::VAL_W'(v[c]);
				r.avg = mws_pkg::VAL_W'(v[c]);
				r.sd = '0;
				r.fin = (c == mws_pkg::CHANNELS - 1);
				res.push_back(r);
			end
		end
		foreach (res[i]) pending_stats.push_back(res[i]);
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic settle_and_write(input int w);
		start <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
		wr_en <= 1'b1;
		wr_data <= w[mws_pkg::WLEN_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		win_len = w & 11'h7FF;
	endtask

	function automatic int rand_chan(int c);
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return (c < mws_pkg::SIGNED_CH) ? -32768 : 0;
		if (r == 1) return (c < mws_pkg::SIGNED_CH) ? 32767 : 65535;
		r = $urandom_range(0, 65535);
		return (c < mws_pkg::SIGNED_CH && r > 32767) ? r - 65536 : r;
	endfunction

	stim_row_t dir_tab [] = '{
		'{1, 0,    0, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    1, '{-32768, -32768, -32768, 0, 0, 0, 0}},
		'{0, 0,    1, '{32767, 32767, 32767, 65535, 65535, 65535, 65535}},
		'{0, 0,    1, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    1, '{-1, -1, -1, 1, 1, 1, 1}},
		'{0, 0,    1, '{21845, -21846, 1, 43690, 21845, 32768, 32767}},
		'{1, 2,    0, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    0, '{32767, 32767, -32768, 65535, 0, 65535, 0}},
		'{0, 0,    0, '{-32768, -32768, 32767, 0, 65535, 0, 65535}},
		'{0, 0,    0, '{-1, -1, 5, 3, 100, 7, 8}},
		'{0, 0,    0, '{-2, -4, -6, 4, 101, 8, 9}},
		'{1, 3,    0, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    0, '{-100, 200, -300, 400, 500, 600, 700}},
		'{0, 0,    0, '{1234, -5678, 9, 60000, 12, 5, 40000}},
		'{0, 0,    0, '{-7, 7, 0, 1, 2, 3, 4}},
		'{1, 5,    0, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    0, '{10, 20, 30, 40, 50, 60, 70}},
		'{0, 0,    0, '{-10, -20, -30, 4, 5, 6, 7}},
		'{0, 0,    0, '{3, 3, 3, 3, 3, 3, 3}},
		// window shrinks below the records already taken
		'{1, 2,    0, '{0, 0, 0, 0, 0, 0, 0}},
		'{0, 0,    0, '{99, -99, 0, 65535, 0, 1, 2}}
	};

	initial begin
		int v[mws_pkg::CHANNELS];
		int sent, w, k;
		win_len = mws_pkg::WLEN_RESET;
		rec_count = 0;
		for (int c = 0; c < mws_pkg::CHANNELS; c++) begin
			acc_sum[c] = 0; acc_sq[c] = 0; run_min[c] = 0; run_max[c] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first window at the reset length
		for (int i = 0; i < mws_pkg::WLEN_RESET; i++) begin
			for (int c = 0; c < mws_pkg::CHANNELS; c++) v[c] = rand_chan(c);
			send_record(v, 0, 1);
		end

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) settle_and_write(dir_tab[i].wlen);
			else send_record(dir_tab[i].v, dir_tab[i].glance, 1);
		end

		// length written above the clamp keeps the window open, then a shrink closes it
		settle_and_write(2047);
		for (int i = 0; i < 20; i++) begin
			for (int c = 0; c < mws_pkg::CHANNELS; c++) v[c] = rand_chan(c);
			send_record(v, 0, 1);
		end
		settle_and_write(1);
		for (int c = 0; c < mws_pkg::CHANNELS; c++) v[c] = rand_chan(c);
		send_record(v, 0, 1);

		sent = 0;
		while (sent < 80) begin
			case ($urandom_range(0, 5))
				0: w = 1;
				1: w = 0;
				default: w = $urandom_range(2, 8);
			endcase
			settle_and_write(w);
			k = ((w < 1) ? 1 : w) * $urandom_range(1, 4) + $urandom_range(0, 2);
			for (int i = 0; i < k; i++) begin
				for (int c = 0; c < mws_pkg::CHANNELS; c++) v[c] = rand_chan(c);
				send_record(v, 0, sent < 60);
				sent++;
			end
		end

		start <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0)
			$display("** multichannel_window_statistics: PASSED **");
		else
			$display("** multichannel_window_statistics: FAILED **");
		$finish;
	end
endmodule
